@@ hw/rtl/ccgv_pkg.sv @@
`timescale 1ns / 1ps

package ccgv_pkg;

    // Character class picked by the mode register.
    typedef enum logic [1:0] {
        MODE_DIGIT     = 2'd0,
        MODE_ASCII_SET = 2'd1,
        MODE_GBK_ONLY  = 2'd2,
        MODE_GBK_MIXED = 2'd3
    } class_mode_t;

    // Register index decoded from the word address.
    localparam int unsigned ADDR_WIDTH   = 3;
    localparam int unsigned DATA_WIDTH   = 32;
    localparam logic        REG_CLASS_MODE = 1'b0;

    // Per-string scan state carried from one byte to the next.
    typedef struct packed {
        logic       pair_lead_pending;
        logic [7:0] pair_lead_value;
        logic       gbk_lead_pending;
        logic       seen_failure;
        logic       seen_terminator;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        pair_lead_pending: 1'b0,
        pair_lead_value:   8'd0,
        gbk_lead_pending:  1'b0,
        seen_failure:      1'b0,
        seen_terminator:   1'b0
    };

endpackage

@@ hw/rtl/character_class_gbk_validator.sv @@
`timescale 1ns / 1ps

// Validates a byte string against the character class held in class_mode
// (address 0): digits, an ASCII set with full-width punctuation pairs, GBK
// double-byte only, or mixed ASCII and GBK. One byte is accepted every clock
// cycle while no string-closing byte waits on a full result slot; a byte sits
// in an input register while the scan state is updated, and the pass/fail
// item for a string appears on the result channel the cycle after its last
// byte is taken from that register. The single-byte scan state update sets
// the rate. A write to class_mode starts a new string.
module character_class_gbk_validator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccgv_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [ccgv_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [ccgv_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_char_byte,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_string_ok
);

    ccgv_pkg::class_mode_t mode_reg;
    ccgv_pkg::scan_state_t state_reg;
    ccgv_pkg::scan_state_t state_step;
    logic                  in_valid_reg;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic                  ok_reg;
    logic                  step_ok;
    logic                  advance;
    logic                  cfg_write;
    logic                  reg_sel;

    // Register port decode.
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && (reg_sel == ccgv_pkg::REG_CLASS_MODE);
    assign pready    = 1'b1;
    assign prdata    = (reg_sel == ccgv_pkg::REG_CLASS_MODE) ?
                       {{(ccgv_pkg::DATA_WIDTH-2){1'b0}}, mode_reg} : '0;

    // The held byte moves on unless it closes a string and the result slot is full.
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ccgv_step u_step (
        .mode       (mode_reg),
        .state_cur  (state_reg),
        .char_byte  (byte_reg),
        .last_byte  (last_reg),
        .state_next (state_step),
        .string_ok  (step_ok)
    );

    // Control state: mode, scan state and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ccgv_pkg::MODE_DIGIT;
            state_reg     <= ccgv_pkg::SCAN_CLEAR;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                mode_reg  <= ccgv_pkg::class_mode_t'(pwdata[1:0]);
                state_reg <= ccgv_pkg::SCAN_CLEAR;
            end else if (advance) begin
                state_reg <= state_step;
            end
        end
    end

    // Payload registers on both sides.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_char_byte;
            last_reg <= s_last_byte;
        end
        if (advance && last_reg) begin
            ok_reg <= step_ok;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_string_ok = ok_reg;

endmodule

@@ hw/rtl/ccgv_step.sv @@
`timescale 1ns / 1ps

module ccgv_step (
    input  ccgv_pkg::class_mode_t mode,
    input  ccgv_pkg::scan_state_t state_cur,
    input  logic [7:0]            char_byte,
    input  logic                  last_byte,
    output ccgv_pkg::scan_state_t state_next,
    output logic                  string_ok
);

    localparam logic [7:0] CH_DIGIT_LO   = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI   = 8'd57;
    localparam logic [7:0] LEAD_A1       = 8'd161;
    localparam logic [7:0] LEAD_A3       = 8'd163;
    localparam logic [7:0] HIGH_LIMIT    = 8'd128;
    localparam logic [7:0] TRAIL_LO      = 8'd64;
    localparam logic [7:0] TRAIL_HI      = 8'd254;

    // Plain ASCII bytes accepted by the extended set.
    function automatic logic in_ascii_set(input logic [7:0] b);
        logic hit;
        hit = (b == 8'd10) || (b == 8'd13) || (b == 8'd94) || (b == 8'd124) ||
              (b >= 8'd32 && b <= 8'd35) || (b >= 8'd38 && b <= 8'd57) ||
              (b >= 8'd59 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
        return hit;
    endfunction

    // Full-width punctuation pairs accepted by the extended set.
    function automatic logic pair_ok(input logic [7:0] lead, input logic [7:0] trail);
        logic hit;
        hit = 1'b0;
        if (lead == LEAD_A1) begin
            hit = (trail == 8'd163) || (trail == 8'd177) || (trail == 8'd175);
        end else if (lead == LEAD_A3) begin
            hit = (trail == 8'd172) || (trail == 8'd161) || (trail == 8'd168) ||
                  (trail == 8'd169) || (trail == 8'd191);
        end
        return hit;
    endfunction

    ccgv_pkg::scan_state_t st;
    logic                  high_byte;
    logic                  trail_fits;

    assign high_byte  = (char_byte > HIGH_LIMIT);
    assign trail_fits = (char_byte >= TRAIL_LO) && (char_byte <= TRAIL_HI);

    // Apply one byte to the scan state, then close the string on the last byte.
    always_comb begin
        st        = state_cur;
        string_ok = 1'b0;
        if (!st.seen_terminator) begin
            if (char_byte == 8'd0) begin
                // A lead byte still open at the terminator is a failure.
                if (st.pair_lead_pending || st.gbk_lead_pending) begin
                    st.seen_failure = 1'b1;
                end
                st.pair_lead_pending = 1'b0;
                st.pair_lead_value   = 8'd0;
                st.gbk_lead_pending  = 1'b0;
                st.seen_terminator   = 1'b1;
            end else begin
                case (mode)
                    ccgv_pkg::MODE_DIGIT: begin
                        if (char_byte < CH_DIGIT_LO || char_byte > CH_DIGIT_HI) begin
                            st.seen_failure = 1'b1;
                        end
                    end
                    ccgv_pkg::MODE_ASCII_SET: begin
                        if (st.pair_lead_pending) begin
                            if (!pair_ok(st.pair_lead_value, char_byte)) begin
                                st.seen_failure = 1'b1;
                            end
                            st.pair_lead_pending = 1'b0;
                            st.pair_lead_value   = 8'd0;
                        end else if (!in_ascii_set(char_byte)) begin
                            if (char_byte == LEAD_A1 || char_byte == LEAD_A3) begin
                                st.pair_lead_pending = 1'b1;
                                st.pair_lead_value   = char_byte;
                            end else begin
                                st.seen_failure = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Both GBK modes share the lead and trail pairing.
                        if (mode == ccgv_pkg::MODE_GBK_ONLY) begin
                            if (!high_byte) begin
                                st.seen_failure = 1'b1;
                            end
                        end else if (!in_ascii_set(char_byte) && !high_byte) begin
                            st.seen_failure = 1'b1;
                        end
                        if (st.gbk_lead_pending) begin
                            if (!trail_fits) begin
                                st.seen_failure = 1'b1;
                            end
                            st.gbk_lead_pending = 1'b0;
                        end else if (high_byte) begin
                            st.gbk_lead_pending = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (last_byte) begin
            // An unterminated string must not end inside a pair.
            if (!st.seen_terminator && (st.pair_lead_pending || st.gbk_lead_pending)) begin
                st.seen_failure = 1'b1;
            end
            string_ok = !st.seen_failure;
            st        = ccgv_pkg::SCAN_CLEAR;
        end
        state_next = st;
    end

endmodule

@@ bench/tb_character_class_gbk_validator.sv @@
`timescale 1ns / 1ps

module tb_character_class_gbk_validator;

    localparam int unsigned ADDR_BITS = ccgv_pkg::ADDR_WIDTH;
    localparam logic [ccgv_pkg::ADDR_WIDTH-1:0] MODE_ADDR =
        ADDR_BITS'(4 * ccgv_pkg::REG_CLASS_MODE);
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS = 150;

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ccgv_pkg::ADDR_WIDTH-1:0] paddr;
    logic [ccgv_pkg::DATA_WIDTH-1:0] pwdata;
    logic [ccgv_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;
    logic                            s_valid;
    logic                            s_ready;
    logic [7:0]                      s_char_byte;
    logic                            s_last_byte;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_string_ok;

    // Scan state of the predictor, mirroring the string state of the block.
    ccgv_pkg::class_mode_t active_mode = ccgv_pkg::MODE_DIGIT;
    logic        pair_pending = 1'b0;
    logic [7:0]  pair_lead = 8'd0;
    logic        gbk_pending = 1'b0;
    logic        string_failed = 1'b0;
    logic        string_ended = 1'b0;

    // Pass/fail verdicts still owed by the block, oldest first.
    logic string_ok_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    character_class_gbk_validator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_string_ok (m_string_ok)
    );

    // Free-running clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Bytes allowed by the ASCII set of the extended class.
    function automatic logic in_ascii_class(input logic [7:0] b);
        return b == 8'd10 || b == 8'd13 || b == 8'd94 || b == 8'd124 ||
               (b >= 8'd32 && b <= 8'd35) || (b >= 8'd38 && b <= 8'd57) ||
               (b >= 8'd59 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
    endfunction

    // Full-width punctuation pairs accepted in the extended class.
    function automatic logic punct_pair_ok(input logic [7:0] lead, input logic [7:0] trail);
        if (lead == 8'd161)
            return trail == 8'd163 || trail == 8'd177 || trail == 8'd175;
        if (lead == 8'd163)
            return trail == 8'd172 || trail == 8'd161 || trail == 8'd168 ||
                   trail == 8'd169 || trail == 8'd191;
        return 1'b0;
    endfunction

    function automatic logic [15:0] punct_pair(input int unsigned idx);
        case (idx)
            0: return {8'd161, 8'd163};
            1: return {8'd163, 8'd172};
            2: return {8'd163, 8'd161};
            3: return {8'd163, 8'd168};
            4: return {8'd163, 8'd169};
            5: return {8'd163, 8'd191};
            6: return {8'd161, 8'd177};
            default: return {8'd161, 8'd175};
        endcase
    endfunction

    function automatic void clear_scan();
        pair_pending = 1'b0;
        pair_lead = 8'd0;
        gbk_pending = 1'b0;
        string_failed = 1'b0;
        string_ended = 1'b0;
    endfunction

    // GBK lead/trail pairing shared by the two double-byte classes.
    function automatic void gbk_pairing(input logic [7:0] b);
        if (gbk_pending) begin
            if (b < 8'd64 || b > 8'd254)
                string_failed = 1'b1;
            gbk_pending = 1'b0;
        end else if (b > 8'd128) begin
            gbk_pending = 1'b1;
        end
    endfunction

    // Advances the predicted scan by one byte and queues a verdict on the last one.
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        if (!string_ended) begin
            if (b == 8'd0) begin
                if (pair_pending || gbk_pending)
                    string_failed = 1'b1;
                pair_pending = 1'b0;
                pair_lead = 8'd0;
                gbk_pending = 1'b0;
                string_ended = 1'b1;
            end else begin
                case (active_mode)
                    ccgv_pkg::MODE_DIGIT: begin
                        if (b < 8'd48 || b > 8'd57)
                            string_failed = 1'b1;
                    end
                    ccgv_pkg::MODE_ASCII_SET: begin
                        if (pair_pending) begin
                            if (!punct_pair_ok(pair_lead, b))
                                string_failed = 1'b1;
                            pair_pending = 1'b0;
                            pair_lead = 8'd0;
                        end else if (!in_ascii_class(b)) begin
                            if (b == 8'd161 || b == 8'd163) begin
                                pair_pending = 1'b1;
                                pair_lead = b;
                            end else begin
                                string_failed = 1'b1;
                            end
                        end
                    end
                    ccgv_pkg::MODE_GBK_ONLY: begin
                        if (b <= 8'd128)
                            string_failed = 1'b1;
                        gbk_pairing(b);
                    end
                    default: begin
                        if (!in_ascii_class(b) && b <= 8'd128)
                            string_failed = 1'b1;
                        gbk_pairing(b);
                    end
                endcase
            end
        end
        if (last) begin
            if (!string_ended && (pair_pending || gbk_pending))
                string_failed = 1'b1;
            string_ok_q.push_back(!string_failed);
            clear_scan();
        end
    endfunction

    // Offers one byte, holding it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_char_byte = b;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        scan_byte(b, last);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (string_ok_q.size() != 0)
            @(posedge aclk);
    endtask

    // Writes the mode while the block is idle, then reads it back.
    task automatic write_mode(input ccgv_pkg::class_mode_t mode);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = MODE_ADDR;
        pwdata = 32'(mode);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        active_mode = mode;
        clear_scan();
        @(negedge aclk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(mode))
            report_mismatch($sformatf("class_mode read %0d, wrote %0d", prdata, mode));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Digits only, using the mode left by reset.
    task automatic test_digit_class();
        send_byte(8'd48, 1'b0);
        send_byte(8'd57, 1'b1);
        send_byte(8'd58, 1'b1);
        send_byte(8'd0, 1'b1);
    endtask

    // ASCII set with punctuation pairs, a bad pair and a byte outside the set.
    task automatic test_ascii_set_class();
        write_mode(ccgv_pkg::MODE_ASCII_SET);
        send_byte(8'd163, 1'b0);
        send_byte(8'd191, 1'b0);
        send_byte(8'd124, 1'b1);
        send_byte(8'd161, 1'b0);
        send_byte(8'd172, 1'b1);
        send_byte(8'd36, 1'b1);
    endtask

    // Double-byte only: a good pair, a trail above range and a low byte.
    task automatic test_gbk_only_class();
        write_mode(ccgv_pkg::MODE_GBK_ONLY);
        send_byte(8'd129, 1'b0);
        send_byte(8'd254, 1'b1);
        send_byte(8'd254, 1'b0);
        send_byte(8'd255, 1'b1);
        send_byte(8'd128, 1'b1);
    endtask

    // Mixed text: a lead cut off by the terminator, bytes after the terminator
    // that must be ignored, and a lead left open at the last byte.
    task automatic test_gbk_mixed_class();
        write_mode(ccgv_pkg::MODE_GBK_MIXED);
        send_byte(8'd103, 1'b0);
        send_byte(8'd200, 1'b0);
        send_byte(8'd65, 1'b0);
        send_byte(8'd200, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd1, 1'b1);
        send_byte(8'd200, 1'b1);
    endtask

    // A mode write in the middle of a string drops the pending lead.
    task automatic test_mode_write_restart();
        send_byte(8'd200, 1'b0);
        write_mode(ccgv_pkg::MODE_GBK_MIXED);
        send_byte(8'd65, 1'b1);
    endtask

    // Builds one mostly well-formed string for the active mode and sends it.
    task automatic send_random_string();
        logic [7:0]  str_q[$];
        logic [7:0]  b;
        logic [15:0] pair;
        int unsigned len;
        int unsigned roll;
        len = $urandom_range(1, 10);
        while (str_q.size() < len) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                str_q.push_back(8'd0);
            end else if (roll < 14) begin
                str_q.push_back(8'($urandom_range(255)));
            end else begin
                case (active_mode)
                    ccgv_pkg::MODE_DIGIT:
                        str_q.push_back(8'd48 + 8'($urandom_range(9)));
                    ccgv_pkg::MODE_ASCII_SET: begin
                        if ($urandom_range(4) == 0) begin
                            pair = punct_pair($urandom_range(7));
                            str_q.push_back(pair[15:8]);
                            str_q.push_back(pair[7:0]);
                        end else begin
                            do b = 8'($urandom_range(10, 124)); while (!in_ascii_class(b));
                            str_q.push_back(b);
                        end
                    end
                    ccgv_pkg::MODE_GBK_ONLY: begin
                        str_q.push_back(8'($urandom_range(129, 255)));
                        str_q.push_back(8'($urandom_range(129, 254)));
                    end
                    default: begin
                        if ($urandom_range(1) == 0) begin
                            do b = 8'($urandom_range(10, 124)); while (!in_ascii_class(b));
                            str_q.push_back(b);
                        end else begin
                            str_q.push_back(8'($urandom_range(129, 255)));
                            str_q.push_back(8'($urandom_range(64, 254)));
                        end
                    end
                endcase
            end
        end
        // Now and then drop the last byte, which can leave a lead open.
        if (str_q.size() > 1 && $urandom_range(19) == 0)
            void'(str_q.pop_back());
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
        strings_sent++;
    endtask

    // Random strings through every mode under three idling profiles.
    task automatic test_random_strings();
        int unsigned phase_start;
        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: set_idling(32, 48);
                1: set_idling(48, 32);
                default: set_idling(0, 0);
            endcase
            write_mode(ccgv_pkg::class_mode_t'(p % 4));
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                send_random_string();
                if (strings_sent % 40 == 0)
                    wait_results_drained();
            end
        end
    endtask

    // Receiver stalls at random according to the active profile.
    always @(negedge aclk)
        m_ready = ($urandom_range(99) >= recv_stall_pct);

    // Each verdict is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (string_ok_q.size() == 0) begin
                report_mismatch($sformatf("string_ok=%0b with no string pending", m_string_ok));
            end else begin
                if (m_string_ok !== string_ok_q[0])
                    report_mismatch($sformatf("string_ok=%0b, predicted %0b",
                                              m_string_ok, string_ok_q[0]));
                void'(string_ok_q.pop_front());
            end
        end
    end

    // Ends the run if no item, result or register access moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_character_class_gbk_validator failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_char_byte = 8'd0;
        s_last_byte = 1'b0;
        m_ready = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_digit_class();
        test_ascii_set_class();
        test_gbk_only_class();
        test_gbk_mixed_class();
        test_mode_write_restart();
        test_random_strings();

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("tb_character_class_gbk_validator passed");
        else
            $display("tb_character_class_gbk_validator failed");
        $finish;
    end

endmodule
